FILE: rtl/stt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the source text tokenizer.
// No dependencies; imported by every module of the block.
package stt_pkg;

    // Width of the line, column and length counters (saturating).
    localparam int POS_BITS    = 16;
    localparam int OUT_POS_W   = 16;
    localparam int INT_W       = 31;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int TDATA_W     = 88;

    typedef enum logic [2:0] {
        KIND_END   = 3'd0,
        KIND_IDENT = 3'd1,
        KIND_INT   = 3'd2,
        KIND_ARROW = 3'd3,
        KIND_MINUS = 3'd4,
        KIND_CHAR  = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [7:0]             chr;
        logic [OUT_POS_W-1:0]   line;
        logic [OUT_POS_W-1:0]   col;
        logic [OUT_POS_W-1:0]   len;
        logic [INT_W-1:0]       val;
    } t_token;

    // Everything one byte produces: one or two tokens.
    typedef struct packed {
        t_token tok0;
        t_token tok1;
        logic   two;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_qwr;

endpackage

FILE: rtl/source_text_tokenizer.sv
`timescale 1ns / 1ps
// Source text tokenizer, top level. Uses stt_pkg, stt_front, stt_queue, stt_back.
//
// Input stream: one source byte per beat on s_axis (tdata[7:0]); byte 0 ends
// the buffer, flushes any pending token, emits an end token and returns the
// scanner to its reset state.
// Output stream: one token per beat on m_axis. tuser carries the token kind,
// tlast marks the last token caused by one input byte (a byte causes zero,
// one or two tokens). Identifiers, integers and a minus come out when the first
// byte that cannot extend them arrives; an arrow comes out with its '>' byte.
// Path: a token group is written into the queue on the edge that accepts its byte, then registered in the output stage.
// Throughput: one byte per cycle while each byte causes at most one token and the
// receiver is ready; the output stage gives one token per cycle, so the second
// token of a byte goes out on a beat of its own. A four-entry queue of token groups sits between scanner
// and output stage; s_axis tready drops only when that queue is full.
// Reset (synchronous, active low) clears scanner state, queue and output stage.
// A stalled receiver holds the current token steady; bytes keep being taken
// until the queue fills.
module source_text_tokenizer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,  // [7:0] ch
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [7:0] token_char, [23:8] start_line, [39:24] start_column,
    // [55:40] span_length, [86:56] int_value, [87] zero
    output logic [stt_pkg::TDATA_W-1:0] o_m_axis_tdata,
    output logic [2:0]                  o_m_axis_tuser,  // [2:0] token_kind
    output logic                        o_m_axis_tlast   // last_of_run
);
    import stt_pkg::*;

    t_qwr   q_wr;
    t_entry q_head;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;

    stt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_ch    (i_s_axis_tdata),
        .i_full  (q_full),
        .o_ready (o_s_axis_tready),
        .o_wr    (q_wr)
    );

    stt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    stt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .i_empty  (q_empty),
        .o_pop    (q_pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule

FILE: rtl/stt_front.sv
`timescale 1ns / 1ps
// Front end: accepts source bytes, tracks scan state and positions,
// and builds the token group each byte causes. Uses stt_pkg.
module stt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_ch,
    input  logic          i_full,
    output logic          o_ready,
    output stt_pkg::t_qwr o_wr
);
    import stt_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_IDENT = 2'd1,
        MODE_INT   = 2'd2,
        MODE_MINUS = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        BRK_NONE    = 2'd0,
        BRK_WANT_LF = 2'd1,
        BRK_WANT_CR = 2'd2
    } t_brk;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
    localparam logic [INT_W-1:0]    INT_MAX = '1;

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + POS_ONE;
    endfunction

    function automatic logic [OUT_POS_W-1:0] pos16(input logic [POS_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[OUT_POS_W-1:0];
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic t_token mk_tok(input t_kind k, input logic [7:0] c,
                                      input logic [POS_BITS-1:0] ln,
                                      input logic [POS_BITS-1:0] cl,
                                      input logic [OUT_POS_W-1:0] len,
                                      input logic [INT_W-1:0] val);
        t_token t;
        t.kind = k;
        t.chr  = c;
        t.line = pos16(ln);
        t.col  = pos16(cl);
        t.len  = len;
        t.val  = val;
        return t;
    endfunction

    t_mode               r_mode,     n_mode;
    t_brk                r_brk,      n_brk;
    logic [POS_BITS-1:0] r_cur_line, n_cur_line;
    logic [POS_BITS-1:0] r_cur_col,  n_cur_col;
    logic [POS_BITS-1:0] r_tok_line, n_tok_line;
    logic [POS_BITS-1:0] r_tok_col,  n_tok_col;
    logic [POS_BITS-1:0] r_tok_len,  n_tok_len;
    logic [INT_W-1:0]    r_acc,      n_acc;

    logic       accept;
    logic       done;
    logic       has_a, has_b;
    t_token     tok_a, tok_b;
    logic [34:0] acc_x10;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    // acc * 10 + digit as two shifts and two adds
    assign acc_x10 = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {31'b0, i_ch[3:0]};

    always_comb begin
        n_mode     = r_mode;
        n_brk      = r_brk;
        n_cur_line = r_cur_line;
        n_cur_col  = r_cur_col;
        n_tok_line = r_tok_line;
        n_tok_col  = r_tok_col;
        n_tok_len  = r_tok_len;
        n_acc      = r_acc;
        done       = 1'b0;
        has_a      = 1'b0;
        has_b      = 1'b0;
        tok_a      = '0;
        tok_b      = '0;

        if ((r_brk == BRK_WANT_LF && i_ch == CH_LF) ||
            (r_brk == BRK_WANT_CR && i_ch == CH_CR)) begin
            // second half of a CR-LF or LF-CR pair: swallowed
            n_brk = BRK_NONE;
            done  = 1'b1;
        end else begin
            n_brk = BRK_NONE;
            case (r_mode)
                MODE_IDENT: begin
                    if (i_ch == CH_UNDER || is_alpha(i_ch) || is_digit(i_ch)) begin
                        n_tok_len = sat_inc(r_tok_len);
                        n_cur_col = sat_inc(r_cur_col);
                        done      = 1'b1;
                    end else begin
                        has_a  = 1'b1;
                        tok_a  = mk_tok(KIND_IDENT, 8'h00, r_tok_line, r_tok_col,
                                        pos16(r_tok_len), '0);
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_INT: begin
                    if (is_digit(i_ch)) begin
                        n_acc     = (acc_x10 > {4'b0, INT_MAX}) ? INT_MAX
                                                                : acc_x10[INT_W-1:0];
                        n_tok_len = sat_inc(r_tok_len);
                        n_cur_col = sat_inc(r_cur_col);
                        done      = 1'b1;
                    end else begin
                        has_a  = 1'b1;
                        tok_a  = mk_tok(KIND_INT, 8'h00, r_tok_line, r_tok_col,
                                        pos16(r_tok_len), r_acc);
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_MINUS: begin
                    n_mode = MODE_IDLE;
                    has_a  = 1'b1;
                    if (i_ch == CH_GT) begin
                        tok_a     = mk_tok(KIND_ARROW, 8'h00, r_tok_line, r_tok_col,
                                           OUT_POS_W'(2), '0);
                        n_cur_col = sat_inc(r_cur_col);
                        done      = 1'b1;
                    end else begin
                        tok_a = mk_tok(KIND_MINUS, 8'h00, r_tok_line, r_tok_col,
                                       OUT_POS_W'(1), '0);
                    end
                end
                default: ;
            endcase

            if (!done) begin
                if (i_ch == CH_NUL) begin
                    has_b      = 1'b1;
                    tok_b      = mk_tok(KIND_END, 8'h00, r_cur_line, r_cur_col,
                                        OUT_POS_W'(1), '0);
                    n_mode     = MODE_IDLE;
                    n_brk      = BRK_NONE;
                    n_cur_line = POS_ONE;
                    n_cur_col  = POS_ONE;
                    n_tok_line = POS_ONE;
                    n_tok_col  = POS_ONE;
                    n_tok_len  = '0;
                    n_acc      = '0;
                end else if (i_ch == CH_LF || i_ch == CH_CR) begin
                    n_cur_line = sat_inc(r_cur_line);
                    n_cur_col  = POS_ONE;
                    n_brk      = (i_ch == CH_CR) ? BRK_WANT_LF : BRK_WANT_CR;
                end else if (i_ch == CH_SPACE || i_ch == CH_TAB) begin
                    n_cur_col = sat_inc(r_cur_col);
                end else if (i_ch == CH_UNDER || is_alpha(i_ch) || is_digit(i_ch) ||
                             i_ch == CH_MINUS) begin
                    if (is_digit(i_ch)) begin
                        n_mode = MODE_INT;
                        n_acc  = {27'b0, i_ch[3:0]};
                    end else if (i_ch == CH_MINUS) begin
                        n_mode = MODE_MINUS;
                    end else begin
                        n_mode = MODE_IDENT;
                    end
                    n_tok_line = r_cur_line;
                    n_tok_col  = r_cur_col;
                    n_tok_len  = POS_ONE;
                    n_cur_col  = sat_inc(r_cur_col);
                end else begin
                    has_b     = 1'b1;
                    tok_b     = mk_tok(KIND_CHAR, i_ch, r_cur_line, r_cur_col,
                                       OUT_POS_W'(1), '0);
                    n_cur_col = sat_inc(r_cur_col);
                end
            end
        end
    end

    always_comb begin
        o_wr.valid = accept && (has_a || has_b);
        if (has_a) begin
            o_wr.entry.tok0 = tok_a;
            o_wr.entry.tok1 = tok_b;
            o_wr.entry.two  = has_b;
        end else begin
            o_wr.entry.tok0 = tok_b;
            o_wr.entry.tok1 = '0;
            o_wr.entry.two  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_brk      <= BRK_NONE;
            r_cur_line <= POS_ONE;
            r_cur_col  <= POS_ONE;
            r_tok_line <= POS_ONE;
            r_tok_col  <= POS_ONE;
            r_tok_len  <= '0;
            r_acc      <= '0;
        end else if (accept) begin
            r_mode     <= n_mode;
            r_brk      <= n_brk;
            r_cur_line <= n_cur_line;
            r_cur_col  <= n_cur_col;
            r_tok_line <= n_tok_line;
            r_tok_col  <= n_tok_col;
            r_tok_len  <= n_tok_len;
            r_acc      <= n_acc;
        end
    end

endmodule

FILE: rtl/stt_queue.sv
`timescale 1ns / 1ps
// Short queue of token groups between the front end and the output stage.
// Uses stt_pkg.
module stt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  stt_pkg::t_qwr   i_wr,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output stt_pkg::t_entry o_head
);
    import stt_pkg::*;

    localparam logic [QPTR_BITS-1:0] PTR_LAST  = QPTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [QPTR_BITS:0]   CNT_DEPTH = (QPTR_BITS + 1)'(QUEUE_DEPTH);

    t_entry               r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_BITS:0]   r_count;

    assign o_full  = (r_count == CNT_DEPTH);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr.valid) begin
            r_mem[r_wr_ptr] <= i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr.valid) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_wr.valid && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr.valid && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.valid |-> !o_full) else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue popped while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_DEPTH) else $error("queue count out of range");

endmodule

FILE: rtl/stt_back.sv
`timescale 1ns / 1ps
// Output stage: pops token groups and hands out one token per beat,
// marking the last token of each group. Uses stt_pkg.
module stt_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  stt_pkg::t_entry              i_head,
    input  logic                         i_empty,
    output logic                         o_pop,
    output logic                         o_tvalid,
    input  logic                         i_tready,
    output logic [stt_pkg::TDATA_W-1:0]  o_tdata,
    output logic [2:0]                   o_tuser,
    output logic                         o_tlast
);
    import stt_pkg::*;

    logic   r_valid;
    logic   r_pend;
    logic   r_last;
    t_token r_tok;
    t_token r_second;
    logic   out_free;

    assign out_free = !r_valid || i_tready;
    assign o_pop    = out_free && !r_pend && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (out_free) begin
            if (r_pend) begin
                r_tok   <= r_second;
                r_last  <= 1'b1;
                r_pend  <= 1'b0;
                r_valid <= 1'b1;
            end else if (!i_empty) begin
                r_tok    <= i_head.tok0;
                r_last   <= !i_head.two;
                r_second <= i_head.tok1;
                r_pend   <= i_head.two;
                r_valid  <= 1'b1;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_tvalid = r_valid;
    assign o_tlast  = r_last;
    assign o_tuser  = r_tok.kind;
    assign o_tdata  = {1'b0, r_tok.val, r_tok.len, r_tok.col, r_tok.line, r_tok.chr};

    a_pend_has_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_valid && !r_last) else $error("second token without first");

    a_pop_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid) else $error("popped group not presented");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid && !i_tready |=> o_tvalid && $stable(o_tdata) && $stable(o_tuser) &&
        $stable(o_tlast)) else $error("stalled beat changed");

endmodule

FILE: bench/source_text_tokenizer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for source_text_tokenizer: byte beats in, token beats out.
// Depends on stt_pkg and the tokenizer RTL; predicts every token and checks each output beat.
module source_text_tokenizer_tb;
    import stt_pkg::*;

    localparam int RANDOM_BEATS   = 420;
    localparam int TAIL_BEATS     = 100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    localparam logic [7:0] CH_EOB   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    localparam logic [POS_BITS-1:0] POS_MAX   = '1;
    localparam longint unsigned     VALUE_MAX = 64'd2147483647;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_IDENT, SCAN_INT, SCAN_MINUS} t_scan;
    typedef enum logic [1:0] {PAIR_NONE, PAIR_WANT_LF, PAIR_WANT_CR} t_pair;

    typedef struct {
        t_kind                kind;
        logic [7:0]           chr;
        logic [OUT_POS_W-1:0] line;
        logic [OUT_POS_W-1:0] col;
        logic [OUT_POS_W-1:0] len;
        logic [INT_W-1:0]     val;
        logic                 last;
    } t_exp_tok;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [7:0]            s_tdata  = 8'h00;
    logic                  m_tready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [TDATA_W-1:0]    o_m_axis_tdata;
    logic [2:0]            o_m_axis_tuser;
    logic                  o_m_axis_tlast;

    logic [7:0]            byte_q[$];
    t_exp_tok              token_q[$];
    logic                  tail_phase   = 1'b0;
    int                    src_gap      = 0;
    int                    sink_gap     = 0;
    int                    stall_cycles = 0;
    int                    errors       = 0;

    string ident_head = "ABCDEFGHIJKLMNOPQRSTUVWXYZ_abcdefghijklmnopqrstuvwxyz";
    string ident_body = "ABCDEFGHIJKLMNOPQRSTUVWXYZ_abcdefghijklmnopqrstuvwxyz0123456789";
    string punct      = "!\"#$%&'()*+,./:;<=>?@[\\]^`{|}~";

    // Scanner copy
    t_scan                 scan_mode;
    t_pair                 pair_wait;
    logic [POS_BITS-1:0]   line_pos, col_pos, tok_line, tok_col, tok_len;
    longint unsigned       int_acc;

    wire s_fire = s_tvalid && o_s_axis_tready;
    wire m_fire = o_m_axis_tvalid && m_tready;

    source_text_tokenizer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic t_exp_tok make_token(input t_kind k, input logic [7:0] c,
                                            input logic [POS_BITS-1:0] ln,
                                            input logic [POS_BITS-1:0] cl,
                                            input logic [POS_BITS-1:0] ll,
                                            input longint unsigned v);
        t_exp_tok t;
        t.kind = k;
        t.chr  = c;
        t.line = ln;
        t.col  = cl;
        t.len  = ll;
        t.val  = v[INT_W-1:0];
        t.last = 1'b0;
        return t;
    endfunction

    task automatic clear_scan();
        scan_mode = SCAN_IDLE;
        pair_wait = PAIR_NONE;
        line_pos  = POS_BITS'(1);
        col_pos   = POS_BITS'(1);
        tok_line  = POS_BITS'(1);
        tok_col   = POS_BITS'(1);
        tok_len   = '0;
        int_acc   = '0;
    endtask

    task automatic open_token(input t_scan m);
        scan_mode = m;
        tok_line  = line_pos;
        tok_col   = col_pos;
        tok_len   = POS_BITS'(1);
        col_pos   = sat_inc(col_pos);
    endtask

    // Works out the tokens that one accepted byte causes and queues them.
    task automatic tokenise_byte(input logic [7:0] c);
        t_exp_tok run[$];
        bit       arrow_done;
        arrow_done = 1'b0;
        // second half of a CR-LF or LF-CR pair: no position change, no token
        if ((pair_wait == PAIR_WANT_LF && c == CH_LF) ||
            (pair_wait == PAIR_WANT_CR && c == CH_CR)) begin
            pair_wait = PAIR_NONE;
            return;
        end
        pair_wait = PAIR_NONE;

        case (scan_mode)
            SCAN_IDENT: begin
                if (c == CH_UNDER || is_alpha(c) || is_digit(c)) begin
                    tok_len = sat_inc(tok_len);
                    col_pos = sat_inc(col_pos);
                    return;
                end
                run.push_back(make_token(KIND_IDENT, 8'h00, tok_line, tok_col, tok_len, '0));
                scan_mode = SCAN_IDLE;
            end
            SCAN_INT: begin
                if (is_digit(c)) begin
                    int_acc = int_acc * 10 + 64'(c - CH_ZERO);
                    if (int_acc > VALUE_MAX)
                        int_acc = VALUE_MAX;
                    tok_len = sat_inc(tok_len);
                    col_pos = sat_inc(col_pos);
                    return;
                end
                run.push_back(make_token(KIND_INT, 8'h00, tok_line, tok_col, tok_len, int_acc));
                scan_mode = SCAN_IDLE;
            end
            SCAN_MINUS: begin
                scan_mode = SCAN_IDLE;
                if (c == CH_GT) begin
                    run.push_back(make_token(KIND_ARROW, 8'h00, tok_line, tok_col,
                                             POS_BITS'(2), '0));
                    col_pos    = sat_inc(col_pos);
                    arrow_done = 1'b1;
                end else begin
                    run.push_back(make_token(KIND_MINUS, 8'h00, tok_line, tok_col,
                                             POS_BITS'(1), '0));
                end
            end
            default: ;
        endcase

        if (!arrow_done) begin
            if (c == CH_EOB) begin
                run.push_back(make_token(KIND_END, 8'h00, line_pos, col_pos,
                                         POS_BITS'(1), '0));
                clear_scan();
            end else if (c == CH_LF || c == CH_CR) begin
                line_pos  = sat_inc(line_pos);
                col_pos   = POS_BITS'(1);
                pair_wait = (c == CH_CR) ? PAIR_WANT_LF : PAIR_WANT_CR;
            end else if (c == CH_SPACE || c == CH_TAB) begin
                col_pos = sat_inc(col_pos);
            end else if (c == CH_UNDER || is_alpha(c)) begin
                open_token(SCAN_IDENT);
            end else if (is_digit(c)) begin
                open_token(SCAN_INT);
                int_acc = 64'(c - CH_ZERO);
            end else if (c == CH_MINUS) begin
                open_token(SCAN_MINUS);
            end else begin
                run.push_back(make_token(KIND_CHAR, c, line_pos, col_pos,
                                         POS_BITS'(1), '0));
                col_pos = sat_inc(col_pos);
            end
        end

        if (run.size() > 0)
            run[run.size()-1].last = 1'b1;
        foreach (run[i])
            token_q.push_back(run[i]);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            byte_q.push_back(s[i]);
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // Byte driver: takes beats from byte_q, idles in short random bursts
    always @(posedge i_clk) begin : byte_driver
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_fire)
                tokenise_byte(s_tdata);
            if (!s_tvalid || o_s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (byte_q.size() > 0 && !tail_phase && $urandom_range(0, 5) == 0) begin
                    src_gap  = $urandom_range(0, 6);
                    s_tvalid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    s_tdata  <= byte_q.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            tail_phase <= (byte_q.size() < TAIL_BEATS);
        end
    end

    // Token monitor: stalls in random bursts, checks each beat against the oldest prediction
    always @(posedge i_clk) begin : token_monitor
        t_exp_tok want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_fire) begin
                if (token_q.size() == 0) begin
                    $error("token beat with nothing expected: kind %0d", o_m_axis_tuser);
                    errors++;
                end else begin
                    want = token_q.pop_front();
                    check_field("token_kind",   64'(want.kind), 64'(o_m_axis_tuser));
                    check_field("token_char",   64'(want.chr),  64'(o_m_axis_tdata[7:0]));
                    check_field("start_line",   64'(want.line), 64'(o_m_axis_tdata[23:8]));
                    check_field("start_column", 64'(want.col),  64'(o_m_axis_tdata[39:24]));
                    check_field("span_length",  64'(want.len),  64'(o_m_axis_tdata[55:40]));
                    check_field("int_value",    64'(want.val),  64'(o_m_axis_tdata[86:56]));
                    check_field("last_of_run",  64'(want.last), 64'(o_m_axis_tlast));
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
                sink_gap = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || s_fire || m_fire)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        int start_len;
        int n;
        clear_scan();

        // Directed: each token kind, two tokens from one byte, paired breaks,
        // high bytes, integer saturation, pending minus flushed by end of buffer
        push_text("_a9;->-7");
        byte_q.push_back(CH_CR);
        byte_q.push_back(CH_LF);
        byte_q.push_back(CH_LF);
        byte_q.push_back(CH_CR);
        byte_q.push_back(8'hFF);
        byte_q.push_back(8'h80);
        push_text("9999999999\t-");
        byte_q.push_back(CH_EOB);

        // Random: mostly well-formed tokens, some noise and stray end bytes
        start_len = byte_q.size();
        while (byte_q.size() - start_len < RANDOM_BEATS) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    n = $urandom_range(1, 8);
                    byte_q.push_back(ident_head[$urandom_range(0, ident_head.len() - 1)]);
                    repeat (n - 1)
                        byte_q.push_back(ident_body[$urandom_range(0, ident_body.len() - 1)]);
                end
                3, 4: begin
                    repeat ($urandom_range(1, 12))
                        byte_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                end
                5: begin
                    if ($urandom_range(0, 1))
                        push_text("->");
                    else
                        byte_q.push_back(CH_MINUS);
                end
                6: begin
                    byte_q.push_back(punct[$urandom_range(0, punct.len() - 1)]);
                end
                7: begin
                    case ($urandom_range(0, 5))
                        0: byte_q.push_back(CH_SPACE);
                        1: byte_q.push_back(CH_TAB);
                        2: byte_q.push_back(CH_CR);
                        3: byte_q.push_back(CH_LF);
                        4: begin
                            byte_q.push_back(CH_CR);
                            byte_q.push_back(CH_LF);
                        end
                        default: begin
                            byte_q.push_back(CH_LF);
                            byte_q.push_back(CH_CR);
                        end
                    endcase
                end
                8: begin
                    byte_q.push_back(8'($urandom_range(1, 255)));
                end
                default: begin
                    if ($urandom_range(0, 19) == 0)
                        byte_q.push_back(CH_EOB);
                    else
                        byte_q.push_back(8'($urandom_range(0, 255)));
                end
            endcase
            // half the time tokens abut, so the flush and the next token share a byte
            case ($urandom_range(0, 3))
                0: byte_q.push_back(CH_SPACE);
                1: byte_q.push_back(CH_LF);
                default: ;
            endcase
        end
        byte_q.push_back(CH_EOB);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((byte_q.size() != 0 || s_tvalid || token_q.size() != 0) &&
               stall_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);

        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $error("no beat moved for %0d cycles, %0d tokens outstanding",
                   stall_cycles, token_q.size());
            $display("TEST FAILED");
            $finish;
        end else begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            if (errors == 0)
                $display("TEST PASSED");
            else
                $display("TEST FAILED");
            $finish;
        end
    end

endmodule

FILE: source_text_tokenizer.f
rtl/stt_pkg.sv
rtl/stt_front.sv
rtl/stt_queue.sv
rtl/stt_back.sv
rtl/source_text_tokenizer.sv
bench/source_text_tokenizer_tb.sv
